/* rtl/core/crcc_pkg.sv */
// Package for the counter rate calibrate and convert core.
// Holds transaction types, status and opcode constants, and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package crcc_pkg;

    localparam logic OP_CAL  = 1'b0;
    localparam logic OP_CONV = 1'b1;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_ALREADY      = 3'd1;
    localparam logic [2:0] ST_NOT_COUNTING = 3'd2;
    localparam logic [2:0] ST_BACKWARDS    = 3'd3;
    localparam logic [2:0] ST_RANGE        = 3'd4;
    localparam logic [2:0] ST_UNCAL        = 3'd5;

    localparam int unsigned RATE_W   = 35;
    localparam int unsigned DIV_STEPS = 64;

    localparam logic [31:0] FREQ_RESET = 32'd3579545;
    localparam logic [63:0] RATE_CEIL  = 64'd18000000000;
    localparam logic [31:0] NS_PER_SEC = 32'd1000000000;

    typedef struct packed {
        logic        opcode;
        logic [63:0] start_count;
        logic [63:0] end_count;
        logic [31:0] ref_tick_count;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] result_value;
    } out_item_t;

    typedef enum logic [1:0] {
        A_SPAN = 2'd0,
        A_QUOT = 2'd1,
        A_REM  = 2'd2
    } a_sel_t;

    typedef enum logic [1:0] {
        V_ZERO = 2'd0,
        V_QUOT = 2'd1,
        V_SUM  = 2'd2
    } val_sel_t;

    typedef struct packed {
        logic       capture;
        a_sel_t     a_sel;
        logic       b_ns;
        logic       mul_en;
        logic       mul_hi;
        logic       acc_first;
        logic       acc_add;
        logic       div_start;
        logic       div_from_acc;
        logic       div_by_ticks;
        logic       save_whole;
        logic       store_rate;
        logic       out_load;
        logic [2:0] out_status;
        val_sel_t   out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic op;
        logic cal;
        logic rate_zero;
        logic freq_zero;
        logic ticks_zero;
        logic span_neg;
        logic span_zero;
        logic ovf;
        logic div_busy;
        logic q_zero;
        logic q_high;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/crcc_dp.sv */
// Datapath: input capture, span subtract, shared 32x32 multiplier with
// accumulator, shared radix-2 divider, rate state and output register.
// Depends on crcc_pkg.
`default_nettype none

module crcc_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire crcc_pkg::in_item_t in_data,
    input  wire logic               cfg_valid,
    input  wire logic [31:0]        cfg_data,
    input  wire crcc_pkg::dp_cmd_t  cmd,
    output crcc_pkg::dp_stat_t      stat,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output crcc_pkg::out_item_t     out_data
);
    import crcc_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_STEPS);

    logic              op_reg;
    logic [63:0]       span_reg;
    logic              neg_reg;
    logic [31:0]       ticks_reg;
    logic [31:0]       freq_reg;
    logic              cal_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [63:0]       prod_reg;
    logic [95:0]       acc_reg;
    logic [63:0]       whole_reg;
    logic [63:0]       dq_reg;
    logic [RATE_W-1:0] dr_reg;
    logic [RATE_W-1:0] dd_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic [64:0]       diff;
    logic [63:0]       a_word;
    logic [31:0]       a_half;
    logic [31:0]       b_word;
    logic [RATE_W:0]   trial;
    logic [63:0]       out_val;

    assign diff = {1'b0, in_data.end_count} - {1'b0, in_data.start_count};

    always_comb
    begin
        case (cmd.a_sel)
            A_SPAN:  a_word = span_reg;
            A_QUOT:  a_word = dq_reg;
            A_REM:   a_word = {{(64 - RATE_W){1'b0}}, dr_reg};
            default: a_word = span_reg;
        endcase
    end

    assign a_half = cmd.mul_hi ? a_word[63:32] : a_word[31:0];
    assign b_word = cmd.b_ns ? NS_PER_SEC : freq_reg;
    assign trial  = {dr_reg, dq_reg[63]} - {1'b0, dd_reg};

    always_comb
    begin
        case (cmd.out_sel)
            V_ZERO:  out_val = 64'd0;
            V_QUOT:  out_val = dq_reg;
            V_SUM:   out_val = whole_reg + dq_reg;
            default: out_val = 64'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= in_data.opcode;
            span_reg  <= diff[63:0];
            neg_reg   <= diff[64];
            ticks_reg <= in_data.ref_tick_count;
        end
        if (cmd.mul_en)
            prod_reg <= a_half * b_word;
        if (cmd.acc_first)
            acc_reg <= {32'd0, prod_reg};
        else if (cmd.acc_add)
            acc_reg <= acc_reg + {prod_reg, 32'd0};
        if (cmd.save_whole)
            whole_reg <= acc_reg[63:0];
        if (cmd.div_start)
        begin
            dq_reg <= cmd.div_from_acc ? acc_reg[63:0] : span_reg;
            dr_reg <= '0;
            dd_reg <= cmd.div_by_ticks ? {{(RATE_W - 32){1'b0}}, ticks_reg} : rate_reg;
        end
        else if (busy_reg)
        begin
            dq_reg <= {dq_reg[62:0], ~trial[RATE_W]};
            dr_reg <= trial[RATE_W] ? {dr_reg[RATE_W-2:0], dq_reg[63]} : trial[RATE_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_data_reg.status       <= cmd.out_status;
            out_data_reg.result_value <= out_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg      <= FREQ_RESET;
            cal_reg       <= 1'b0;
            rate_reg      <= '0;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                freq_reg <= cfg_data;
            if (cmd.store_rate)
            begin
                cal_reg  <= 1'b1;
                rate_reg <= dq_reg[RATE_W-1:0];
            end
            if (cmd.div_start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    busy_reg <= 1'b0;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        stat.op         = op_reg;
        stat.cal        = cal_reg;
        stat.rate_zero  = (rate_reg == '0);
        stat.freq_zero  = (freq_reg == 32'd0);
        stat.ticks_zero = (ticks_reg == 32'd0);
        stat.span_neg   = neg_reg;
        stat.span_zero  = (span_reg == 64'd0);
        stat.ovf        = |acc_reg[95:64];
        stat.div_busy   = busy_reg;
        stat.q_zero     = (dq_reg == 64'd0);
        stat.q_high     = (dq_reg > RATE_CEIL);
        stat.out_busy   = out_valid_reg && out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        cal_reg |=> cal_reg)
        else $error("calibrated flag dropped");

    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_reg |-> (rate_reg != '0) && ({{(64 - RATE_W){1'b0}}, rate_reg} <= RATE_CEIL))
        else $error("stored rate out of range");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

`default_nettype wire

/* rtl/core/crcc_ctrl.sv */
// Controller: one-hot sequencer that steps the datapath through the
// checks, multiply and divide phases of each transaction.
// Depends on crcc_pkg.
`default_nettype none

module crcc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire crcc_pkg::dp_stat_t stat,
    output crcc_pkg::dp_cmd_t       cmd
);
    import crcc_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CHECK  = 9'b000000010,
        S_MUL0   = 9'b000000100,
        S_MUL1   = 9'b000001000,
        S_MUL2   = 9'b000010000,
        S_MCHK   = 9'b000100000,
        S_DIV    = 9'b001000000,
        S_DIVEND = 9'b010000000,
        S_FIN    = 9'b100000000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic       phase_reg;
    logic       phase_next;
    logic [2:0] fin_status_reg;
    logic [2:0] fin_status_next;
    val_sel_t   fin_sel_reg;
    val_sel_t   fin_sel_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd             = '0;
        cmd.a_sel       = (stat.op == OP_CAL) ? A_SPAN : (phase_reg ? A_REM : A_QUOT);
        cmd.b_ns        = (stat.op == OP_CONV);
        cmd.out_status  = fin_status_reg;
        cmd.out_sel     = fin_sel_reg;
        state_next      = state_reg;
        phase_next      = phase_reg;
        fin_status_next = fin_status_reg;
        fin_sel_next    = fin_sel_reg;

        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
                phase_next  = 1'b0;
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next   = S_FIN;
                fin_sel_next = V_ZERO;
                if (stat.op == OP_CAL)
                begin
                    if (stat.cal)
                        fin_status_next = ST_ALREADY;
                    else if (stat.freq_zero || stat.ticks_zero)
                        fin_status_next = ST_NOT_COUNTING;
                    else if (stat.span_neg)
                        fin_status_next = ST_BACKWARDS;
                    else if (stat.span_zero)
                        fin_status_next = ST_NOT_COUNTING;
                    else
                        state_next = S_MUL0;
                end
                else
                begin
                    if (!stat.cal || stat.rate_zero)
                        fin_status_next = ST_UNCAL;
                    else if (stat.span_neg)
                        fin_status_next = ST_BACKWARDS;
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_MUL0:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_hi    = 1'b1;
                cmd.acc_first = 1'b1;
                state_next    = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.acc_add = 1'b1;
                state_next  = S_MCHK;
            end
            S_MCHK:
            begin
                if (stat.op == OP_CAL)
                begin
                    if (stat.ovf)
                    begin
                        fin_status_next = ST_RANGE;
                        fin_sel_next    = V_ZERO;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        cmd.div_start    = 1'b1;
                        cmd.div_from_acc = 1'b1;
                        cmd.div_by_ticks = 1'b1;
                        state_next       = S_DIV;
                    end
                end
                else if (!phase_reg)
                begin
                    cmd.save_whole = 1'b1;
                    phase_next     = 1'b1;
                    state_next     = S_MUL0;
                end
                else
                begin
                    cmd.div_start    = 1'b1;
                    cmd.div_from_acc = 1'b1;
                    state_next       = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!stat.div_busy)
                    state_next = S_DIVEND;
            end
            S_DIVEND:
            begin
                if (stat.op == OP_CAL)
                begin
                    state_next   = S_FIN;
                    fin_sel_next = V_ZERO;
                    if (stat.q_zero)
                        fin_status_next = ST_NOT_COUNTING;
                    else if (stat.q_high)
                        fin_status_next = ST_RANGE;
                    else
                    begin
                        cmd.store_rate  = 1'b1;
                        fin_status_next = ST_OK;
                        fin_sel_next    = V_QUOT;
                    end
                end
                else if (!phase_reg)
                    state_next = S_MUL0;
                else
                begin
                    fin_status_next = ST_OK;
                    fin_sel_next    = V_SUM;
                    state_next      = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= 1'b0;
            fin_status_reg <= ST_OK;
            fin_sel_reg    <= V_ZERO;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            fin_status_reg <= fin_status_next;
            fin_sel_reg    <= fin_sel_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !stat.out_busy)
        else $error("output register overwritten while stalled");

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_CHECK))
        else $error("accepted transaction not checked");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

endmodule

`default_nettype wire

/* rtl/core/counter_rate_calibrate_and_convert_core.sv */
// Counter rate calibrate and convert core: measures a counter rate against
// a reference timer, then converts counter spans to nanoseconds.
// Channels: in_valid/in_stall/in_data (crcc_pkg::in_item_t) carries opcode
//   0 calibrate or 1 convert; out_valid/out_stall/out_data
//   (crcc_pkg::out_item_t) returns status and result_value, one per item.
// Config: cfg_valid/cfg_ready/cfg_data writes reference_frequency_hz;
//   cfg_ready is always high. Write only while the core is idle.
// Sequence: items rejected by the early checks go straight to the output
//   register, as does a calibrate rejected on product overflow. The
//   64-step radix-2 divider is used once by a calibrate and twice by a
//   convert, plus a shared 32x32 multiplier that builds each 64x32 product
//   in S_MUL0, S_MUL1 and S_MUL2 and hands it on in S_MCHK, which checks a
//   calibrate product for overflow.
// Throughput: one transaction at a time; the next is accepted once the
//   result has moved to the output register.
// Reset: asynchronous, active low; clears calibration, sets the reference
//   frequency to 3579545 Hz and drops out_valid.
// Stall: a stalled result holds in the output register; the next item can
//   be processed, but its result waits until the output register frees.
// Depends on crcc_pkg, crcc_ctrl, crcc_dp.
`default_nettype none

module counter_rate_calibrate_and_convert_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire crcc_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output crcc_pkg::out_item_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [31:0]         cfg_data
);
    import crcc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    crcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    crcc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Testbench for counter_rate_calibrate_and_convert_core: directed and random calibrate and
// convert transactions, checked against an in-bench predictor of rate and span in nanoseconds.
// Depends on crcc_pkg and the core RTL.
`default_nettype none

module testbench;
    import crcc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    // predictor state
    logic [31:0] freq_setting = FREQ_RESET;
    logic        cal_locked = 1'b0;
    logic [34:0] locked_rate = '0;

    out_item_t   awaited_replies[$];
    out_item_t   head_reply;
    int          mismatch_count = 0;
    int          results_checked = 0;
    int          cal_sent = 0;
    int          conv_sent = 0;
    int          cfg_writes = 0;
    int          status_seen[8];
    int          burst_left = 0;
    int          quiet_cycles = 0;
    int          stall_mode = 0;
    int          stall_left = 0;

    counter_rate_calibrate_and_convert_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic in_item_t make_item(input logic op, input logic [63:0] s,
                                           input logic [63:0] e, input logic [31:0] ticks);
        in_item_t it;
        it.opcode         = op;
        it.start_count    = s;
        it.end_count      = e;
        it.ref_tick_count = ticks;
        return it;
    endfunction

    function automatic logic [2:0] measure_rate(input logic [63:0] s, input logic [63:0] e,
                                                input logic [31:0] hz,
                                                input logic [31:0] ticks,
                                                output logic [63:0] rate);
        logic [63:0]  span;
        logic [127:0] prod;
        logic [63:0]  r;
        rate = '0;
        if (hz == 0 || ticks == 0)
            return ST_NOT_COUNTING;
        if (e < s)
            return ST_BACKWARDS;
        if (e == s)
            return ST_NOT_COUNTING;
        span = e - s;
        prod = span * hz;
        if (prod[127:64] != 0)
            return ST_RANGE;
        r = prod[63:0] / ticks;
        if (r == 0)
            return ST_NOT_COUNTING;
        if (r > RATE_CEIL)
            return ST_RANGE;
        rate = r;
        return ST_OK;
    endfunction

    // Expected reply for one transaction; updates the calibration state.
    function automatic out_item_t calibrate_or_convert(input in_item_t it);
        out_item_t   res;
        logic [63:0] r;
        logic [63:0] span;
        logic [63:0] whole;
        logic [63:0] frac;
        res.status       = ST_OK;
        res.result_value = '0;
        if (it.opcode == OP_CAL)
        begin
            if (cal_locked)
            begin
                res.status = ST_ALREADY;
            end
            else
            begin
                res.status = measure_rate(it.start_count, it.end_count, freq_setting,
                                          it.ref_tick_count, r);
                if (res.status == ST_OK)
                begin
                    locked_rate      = r[34:0];
                    cal_locked       = 1'b1;
                    res.result_value = {29'd0, locked_rate};
                end
            end
        end
        else if (!cal_locked || locked_rate == 0)
        begin
            res.status = ST_UNCAL;
        end
        else if (it.end_count < it.start_count)
        begin
            res.status = ST_BACKWARDS;
        end
        else
        begin
            span  = it.end_count - it.start_count;
            whole = span / locked_rate;
            frac  = span % locked_rate;
            res.result_value = whole * NS_PER_SEC + (frac * NS_PER_SEC) / locked_rate;
        end
        return res;
    endfunction

    task automatic send_item(input in_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 200);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 10);
        end
        awaited_replies.push_back(calibrate_or_convert(item));
        if (item.opcode == OP_CAL)
            cal_sent++;
        else
            conv_sent++;
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        burst_left--;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited_replies.size() != 0);
    endtask

    task automatic write_frequency(input logic [31:0] hz);
        cfg_valid <= 1'b1;
        cfg_data  <= hz;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        freq_setting = hz;
        cfg_writes++;
    endtask

    // Calibrate transactions that never succeed, mixed with converts.
    function automatic in_item_t uncal_noise();
        in_item_t    it;
        logic [63:0] scratch;
        it.opcode         = ($urandom_range(0, 9) < 3) ? OP_CONV : OP_CAL;
        it.start_count    = rand_word() >> $urandom_range(0, 63);
        it.end_count      = it.start_count + (rand_word() >> $urandom_range(0, 63));
        it.ref_tick_count = $urandom >> $urandom_range(0, 31);
        case ($urandom_range(0, 5))
            0: it.ref_tick_count = '0;
            1: it.end_count = it.start_count >> $urandom_range(1, 63);
            2: it.end_count = it.start_count;
            3:
            begin
                it.start_count    = rand_word();
                it.end_count      = rand_word();
                it.ref_tick_count = $urandom;
            end
            default: ;
        endcase
        if (it.opcode == OP_CAL &&
            measure_rate(it.start_count, it.end_count, freq_setting,
                         it.ref_tick_count, scratch) == ST_OK)
            it.ref_tick_count = '0;
        return it;
    endfunction

    function automatic in_item_t span_item();
        in_item_t    it;
        logic [63:0] span;
        it.opcode         = OP_CONV;
        it.ref_tick_count = $urandom;
        it.start_count    = rand_word();
        span              = rand_word() >> $urandom_range(0, 63);
        case ($urandom_range(0, 19))
            0, 1:
            begin
                it.opcode    = OP_CAL;
                it.end_count = rand_word();
            end
            2: it.end_count = it.start_count >> $urandom_range(1, 63);
            3: it.end_count = it.start_count;
            4:
            begin
                span = locked_rate * $urandom_range(0, 1000) +
                       (($urandom_range(0, 1) == 0) ? locked_rate - 1 : $urandom_range(0, 3));
                it.start_count = it.start_count & ~span;
                it.end_count   = it.start_count | span;
            end
            5:
            begin
                it.start_count = rand_word();
                it.end_count   = rand_word();
            end
            default:
            begin
                it.start_count = it.start_count & ~span;
                it.end_count   = it.start_count | span;
            end
        endcase
        return it;
    endfunction

    task automatic test_uncalibrated_checks();
        send_item(make_item(OP_CONV, 64'd100, 64'd200, 32'd0));
        send_item(make_item(OP_CONV, 64'd200, 64'd100, 32'd7));
        send_item(make_item(OP_CAL, 64'd0, 64'd1000, 32'd0));
        send_item(make_item(OP_CAL, 64'd1000, 64'd10, 32'd5));
        send_item(make_item(OP_CAL, '1, '1, '1));
        send_item(make_item(OP_CAL, 64'd0, '1, 32'd1));
        send_item(make_item(OP_CAL, 64'd5, 64'd6, '1));
        send_item(make_item(OP_CAL, 64'd0, 64'd10000000, 32'd1));
    endtask

    task automatic test_frequency_extremes();
        wait_drained();
        write_frequency('0);
        send_item(make_item(OP_CAL, 64'd0, 64'd1000, 32'd10));
        wait_drained();
        write_frequency('1);
        send_item(make_item(OP_CAL, 64'd0, 64'h1_0000_0002, 32'd1));
        send_item(make_item(OP_CAL, 64'd10, 64'd15, 32'd1));
        wait_drained();
        write_frequency(32'd1);
        send_item(make_item(OP_CAL, 64'd0, RATE_CEIL + 64'd1, 32'd1));
    endtask

    task automatic test_uncalibrated_random();
        logic [31:0] hz;
        for (int chunk = 0; chunk < 6; chunk++)
        begin
            case (chunk)
                0: hz = $urandom;
                1: hz = '0;
                2: hz = '1;
                3: hz = 32'd1;
                4: hz = $urandom >> $urandom_range(8, 31);
                default: hz = FREQ_RESET;
            endcase
            wait_drained();
            write_frequency(hz);
            repeat (55) send_item(uncal_noise());
        end
    endtask

    task automatic test_calibration();
        logic [31:0]  hz;
        logic [31:0]  ticks;
        logic [63:0]  span;
        logic [63:0]  target;
        logic [63:0]  s;
        logic [63:0]  r;
        logic [127:0] scaled;
        logic [2:0]   st;
        int           mode;
        mode  = $urandom_range(0, 3);
        hz    = FREQ_RESET;
        ticks = 32'd1;
        span  = 64'd1;
        case (mode)
            0:
            begin
                hz    = 32'd1;
                span  = RATE_CEIL;
            end
            1:
            begin
                hz    = 32'd1000;
                ticks = 32'd1000;
                span  = $urandom_range(1, 50);
            end
            default:
            begin
                do
                begin
                    if (mode == 2)
                        hz = $urandom_range(1, 32'hFFFF_FFFF);
                    ticks  = ($urandom >> $urandom_range(0, 31)) | 32'd1;
                    target = (rand_word() % RATE_CEIL) + 64'd1;
                    scaled = (target * ticks) / hz;
                    span   = (scaled == 0) ? 64'd1 : scaled[63:0];
                    st     = ST_RANGE;
                    if (scaled[127:63] == 0)
                        st = measure_rate(64'd0, span, hz, ticks, r);
                end while (st != ST_OK);
            end
        endcase
        wait_drained();
        write_frequency(hz);
        s = rand_word() >> 1;
        send_item(make_item(OP_CAL, s, s + span, ticks));
    endtask

    task automatic test_calibrated_checks();
        logic [63:0] s;
        s = rand_word() >> 2;
        send_item(make_item(OP_CAL, 64'd0, 64'd100, 32'd1));
        send_item(make_item(OP_CONV, 64'd200, 64'd100, 32'd0));
        send_item(make_item(OP_CONV, s, s, 32'd0));
        send_item(make_item(OP_CONV, 64'd0, '1, '1));
        send_item(make_item(OP_CONV, '1, '1, 32'd0));
        send_item(make_item(OP_CONV, s, s + locked_rate, 32'd0));
        send_item(make_item(OP_CONV, s, s + locked_rate - 64'd1, 32'd0));
        wait_drained();
        write_frequency('0);
        send_item(make_item(OP_CAL, 64'd0, 64'd100, 32'd1));
    endtask

    task automatic test_conversion_random();
        for (int chunk = 0; chunk < 7; chunk++)
        begin
            wait_drained();
            write_frequency($urandom);
            repeat (200) send_item(span_item());
        end
    endtask

    // receiver stall pattern: switches between no, light, medium and heavy stalling
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 300);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_replies.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d value %0d",
                         $time, out_data.status, out_data.result_value);
                mismatch_count++;
            end
            else
            begin
                head_reply = awaited_replies.pop_front();
                if (out_data.status !== head_reply.status)
                begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, head_reply.status, out_data.status);
                    mismatch_count++;
                end
                if (out_data.result_value !== head_reply.result_value)
                begin
                    $display("%0t: result_value mismatch, expected %0d actual %0d",
                             $time, head_reply.result_value, out_data.result_value);
                    mismatch_count++;
                end
                results_checked++;
                status_seen[head_reply.status]++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("counter_rate_calibrate_and_convert_core verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_uncalibrated_checks();
        test_frequency_extremes();
        test_uncalibrated_random();
        test_calibration();
        test_calibrated_checks();
        test_conversion_random();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d calibrate, %0d convert, %0d frequency writes, %0d checked.",
                 cal_sent, conv_sent, cfg_writes, results_checked);
        $display("Statuses ok %0d already %0d idle %0d backwards %0d range %0d uncal %0d",
                 status_seen[ST_OK], status_seen[ST_ALREADY], status_seen[ST_NOT_COUNTING],
                 status_seen[ST_BACKWARDS], status_seen[ST_RANGE], status_seen[ST_UNCAL]);
        if (mismatch_count == 0)
            $display("counter_rate_calibrate_and_convert_core verification clean");
        else
            $display("counter_rate_calibrate_and_convert_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
